// ----- hdl/tbp_pkg.sv -----
// shared types, constants and counter functions for the two-bit branch predictor table
// no dependencies
`default_nettype none

package tbp_pkg;

    localparam int ADDR_W             = 32;
    localparam int CFG_W              = 4;
    localparam int MISS_W             = 32;
    localparam int DEF_MAX_INDEX_BITS = 10;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd10;

    typedef logic [1:0] counter_t;

    localparam counter_t CNT_SN = 2'b00;
    localparam counter_t CNT_WN = 2'b01;
    localparam counter_t CNT_WT = 2'b10;
    localparam counter_t CNT_ST = 2'b11;

    function automatic logic predict(input counter_t c);
        return (c == CNT_WT) || (c == CNT_ST);
    endfunction

    // weakly not-taken jumps to strong taken, weakly taken jumps to strong not-taken
    function automatic counter_t next_counter(input counter_t c, input logic tk);
        counter_t r;
        if (tk)
        begin
            r = (c == CNT_SN) ? CNT_WN : CNT_ST;
        end
        else
        begin
            r = (c == CNT_ST) ? CNT_WT : CNT_SN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tbp_counter_mem.sv -----
// counter table memory with registered read and a clearing sweep after reset
// depends on tbp_pkg
`default_nettype none

module tbp_counter_mem #(
    parameter int AW = tbp_pkg::DEF_MAX_INDEX_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output tbp_pkg::counter_t      rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire tbp_pkg::counter_t wr_data,
    output logic                   clearing
);

    tbp_pkg::counter_t mem [2**AW];
    tbp_pkg::counter_t rd_data_reg;
    logic              clearing_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    tbp_pkg::counter_t mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = tbp_pkg::CNT_ST;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

// ----- hdl/two_bit_branch_predictor_table.sv -----
// an accepted request waits in stage 1 with its counter read; its result is registered on the outputs when it advances
// throughput: one request per cycle while out_stall is low and no clearing pass runs
// counter table is read into a register, then prediction and update happen in one stage
// reset: a clearing pass over all 2**MAX_INDEX_BITS entries sets every counter to strongly taken,
// in_stall stays high meanwhile; index_bits resets to 10, miss count to zero
// depends on tbp_pkg and tbp_counter_mem
`default_nettype none

module two_bit_branch_predictor_table #(
    parameter int MAX_INDEX_BITS = tbp_pkg::DEF_MAX_INDEX_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tbp_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tbp_pkg::ADDR_W-1:0]   branch_address,
    input  wire logic                         taken,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              predicted_taken,
    output logic                              mispredicted,
    output logic [tbp_pkg::MISS_W-1:0]        miss_total
);

    localparam int AW = MAX_INDEX_BITS;

    logic [tbp_pkg::CFG_W-1:0]  index_bits_reg;
    logic                       clamp;
    logic [AW-1:0]              idx_mask;
    logic [AW-1:0]              rd_idx;
    logic                       clearing;
    logic                       in_fire;
    logic                       s1_adv;

    logic                       s1_valid_reg;
    logic [AW-1:0]              s1_idx_reg;
    logic                       s1_taken_reg;
    tbp_pkg::counter_t          rd_data;

    logic                       byp_valid_reg;
    logic [AW-1:0]              byp_idx_reg;
    tbp_pkg::counter_t          byp_val_reg;

    tbp_pkg::counter_t          cur;
    tbp_pkg::counter_t          cnt_next;
    logic                       pred;
    logic                       miss;
    logic [tbp_pkg::MISS_W-1:0] miss_cnt_reg;
    logic [tbp_pkg::MISS_W-1:0] miss_cnt_next;

    logic                       out_valid_reg;
    logic                       predicted_taken_reg;
    logic                       mispredicted_reg;
    logic [tbp_pkg::MISS_W-1:0] miss_total_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= tbp_pkg::INDEX_BITS_RESET;
        end
        else if (cfg_valid)
        begin
            index_bits_reg <= cfg_data;
        end
    end

    always_comb
    begin
        clamp = 32'(index_bits_reg) > 32'(MAX_INDEX_BITS);
        for (int i = 0; i < AW; i++)
        begin
            idx_mask[i] = clamp || (32'(i) < 32'(index_bits_reg));
        end
    end

    assign rd_idx   = branch_address[AW-1:0] & idx_mask;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing || (s1_valid_reg && !s1_adv);
    assign in_fire  = in_valid && !in_stall;

    tbp_counter_mem #(
        .AW (AW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_fire),
        .rd_addr  (rd_idx),
        .rd_data  (rd_data),
        .wr_en    (s1_adv),
        .wr_addr  (s1_idx_reg),
        .wr_data  (cnt_next),
        .clearing (clearing)
    );

    // last write forwarded over the stale read
    always_comb
    begin
        cur      = (byp_valid_reg && (byp_idx_reg == s1_idx_reg)) ? byp_val_reg : rd_data;
        pred     = tbp_pkg::predict(cur);
        miss     = pred != s1_taken_reg;
        cnt_next = tbp_pkg::next_counter(cur, s1_taken_reg);
        miss_cnt_next = (miss && (miss_cnt_reg != '1)) ? miss_cnt_reg + 1'b1 : miss_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                byp_valid_reg <= 1'b1;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg   <= rd_idx;
            s1_taken_reg <= taken;
        end
        if (s1_adv)
        begin
            byp_idx_reg         <= s1_idx_reg;
            byp_val_reg         <= cnt_next;
            predicted_taken_reg <= pred;
            mispredicted_reg    <= miss;
            miss_total_reg      <= miss_cnt_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_taken = predicted_taken_reg;
    assign mispredicted    = mispredicted_reg;
    assign miss_total      = miss_total_reg;

`ifndef SYNTH
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("request accepted during clearing pass");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("stalled stage lost its request");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mispredicted) |-> (miss_total != '0))
        else $error("mispredict reported with zero miss count");

    a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (miss_cnt_reg >= $past(miss_cnt_reg)))
        else $error("miss count went backward");
`endif

endmodule

`default_nettype wire
